// ----- rtl/cdjs_pkg.sv -----
// Shared types, constants and helpers for the cascaded damped joint smoother.
package cdjs_pkg;

    localparam int POS_W  = 32;
    localparam int ERR_W  = 33;
    localparam int MV_W   = 24;
    localparam int DT_W   = 24;
    localparam int W_W    = 25;
    localparam int T_W    = 40;
    localparam int ACCV_W = 49;
    localparam int MA_W   = 34;
    localparam int MB_W   = 26;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = 76;
    localparam int NUM_W  = 60;
    localparam int DEN_W  = 42;

    localparam logic [DT_W-1:0]  DT_DEFAULT = 24'd16777;
    localparam logic [NUM_W-1:0] OMEGA_MIN  = 60'd19661;
    localparam logic [NUM_W-1:0] OMEGA_MAX  = 60'd19660800;
    localparam logic signed [59:0] TERM_LIMIT = 60'sd274877906944;

    // accumulator shift codes
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_1  = 2'd1;
    localparam logic [1:0] SH_17 = 2'd2;

    typedef struct packed {
        logic       clr;
        logic       sub;
        logic [1:0] shift;
    } cdjs_mac_op_t;

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [52:0] x);
        logic signed [52:0] hi;
        logic signed [52:0] lo;
        hi = 53'sd2147483647;
        lo = -53'sd2147483648;
        if (x > hi)
            sat32 = 32'sh7fffffff;
        else if (x < lo)
            sat32 = 32'sh80000000;
        else
            sat32 = x[POS_W-1:0];
    endfunction

endpackage

// ----- rtl/cdjs_div.sv -----
// Restoring divider, one quotient bit per cycle.
module cdjs_div
    import cdjs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [5:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_shift;
    logic             fits;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'(NUM_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= fits ? DEN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DEN_W-1:0];
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/cdjs_mac.sv -----
// Shared signed multiply-accumulate unit: product stage, then accumulate stage.
module cdjs_mac
    import cdjs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     issue,
    input  cdjs_mac_op_t             op,
    input  logic signed [MA_W-1:0]   a,
    input  logic signed [MB_W-1:0]   b,
    output logic                     done,
    output logic signed [ACC_W-1:0]  acc
);
    logic signed [PROD_W-1:0] prod_reg;
    cdjs_mac_op_t             op_reg;
    logic                     pend_reg;
    logic                     done_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;

    always_comb
    begin
        term = ACC_W'(prod_reg);
        case (op_reg.shift)
            SH_1:    term = term <<< 1;
            SH_17:   term = term <<< 17;
            default: term = term;
        endcase
        base = op_reg.clr ? '0 : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
            done_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= a * b;
            op_reg   <= op;
        end
        if (pend_reg)
            acc_reg <= op_reg.sub ? base - term : base + term;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// ----- rtl/cascaded_damped_joint_smoother_core.sv -----
// Top level: per-joint state, tick sequencer, divider and shared multiply-accumulate.
// An in-range tick passes prep, divider start, the 60-step divider, 14 MAC ops and a
// hand-off before its result shows; with a zero stage-one error the divide is skipped,
// and a joint out of range goes straight to the hand-off with a zero command.
// One tick at a time: in_ready stays low until the result goes to the output slot.
// Reset (rst_n, async, active low) clears seeded flags and sequences; limit back to 16384.
module cascaded_damped_joint_smoother_core
    import cdjs_pkg::*;
#(
    parameter int JOINT_COUNT = 7
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write_en,
    input  logic [MV_W-1:0]         cfg_write_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              joint,
    input  logic signed [POS_W-1:0] measured_position,
    input  logic signed [POS_W-1:0] target_position,
    input  logic                    target_valid,
    input  logic [31:0]             target_sequence,
    input  logic [DT_W-1:0]         period,
    input  logic                    restart,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              joint_out,
    output logic signed [POS_W-1:0] command_position
);
    localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_DIVGO = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MAC   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // per-joint state; only seeded and the sequence have a reset value
    logic                    seeded_reg  [JOINT_COUNT];
    logic [31:0]             seq_mem_reg [JOINT_COUNT];
    logic signed [POS_W-1:0] goal_reg    [JOINT_COUNT];
    logic signed [POS_W-1:0] p1_mem_reg  [JOINT_COUNT];
    logic signed [POS_W-1:0] v1_mem_reg  [JOINT_COUNT];
    logic signed [POS_W-1:0] p2_mem_reg  [JOINT_COUNT];
    logic signed [POS_W-1:0] v2_mem_reg  [JOINT_COUNT];

    logic [MV_W-1:0]         mv_reg;
    logic [2:0]              state_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [2:0]              joint_reg;
    logic signed [POS_W-1:0] gp_reg, p1_reg, v1_reg, p2_reg, v2_reg;
    logic [31:0]             seq_reg;
    logic [DT_W-1:0]         dt_reg;
    logic [ERR_W-1:0]        mag_reg;
    logic [W_W-1:0]          w_reg;
    logic signed [T_W-1:0]   t_reg;
    logic signed [ACCV_W-1:0] accv_reg;
    logic                    stage_reg;
    logic [2:0]              step_reg;
    logic                    wait_reg;
    logic signed [POS_W-1:0] cmd_reg;
    logic                    out_valid_reg;
    logic [2:0]              joint_out_reg;
    logic signed [POS_W-1:0] command_reg;

    // load path for an accepted transfer
    logic                    accept;
    logic [IDX_W-1:0]        idx_in;
    logic                    in_range;
    logic                    was_seeded;
    logic [31:0]             seq_eff;
    logic signed [POS_W-1:0] gp_ld, p1_ld, v1_ld, p2_ld, v2_ld;
    logic [31:0]             seq_ld;

    assign accept   = in_valid && in_ready;
    assign idx_in   = IDX_W'(joint);
    assign in_range = (32'(joint) < JOINT_COUNT);

    always_comb
    begin
        was_seeded = seeded_reg[idx_in] && !restart;
        seq_eff    = restart ? 32'd0 : seq_mem_reg[idx_in];
        if (was_seeded)
        begin
            gp_ld = goal_reg[idx_in];
            p1_ld = p1_mem_reg[idx_in];
            v1_ld = v1_mem_reg[idx_in];
            p2_ld = p2_mem_reg[idx_in];
            v2_ld = v2_mem_reg[idx_in];
        end
        else
        begin
            gp_ld = measured_position;
            p1_ld = measured_position;
            v1_ld = '0;
            p2_ld = measured_position;
            v2_ld = '0;
        end
        seq_ld = seq_eff;
        if (target_valid && (target_sequence != seq_eff))
        begin
            gp_ld  = target_position;
            seq_ld = target_sequence;
        end
    end

    // stage-one error and its magnitude
    logic signed [ERR_W-1:0] err1;
    assign err1 = ERR_W'(gp_reg) - ERR_W'(p1_reg);

    // divider: omega = mv * 1000 * 2^26 / (264 * |error|)
    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [33:0]      mv_k;

    assign div_start = (state_reg == S_DIVGO) && (mag_reg != '0);
    assign mv_k      = {mv_reg, 10'b0} - {6'b0, mv_reg, 4'b0} - {7'b0, mv_reg, 3'b0};
    assign div_num   = {mv_k, 26'b0};
    assign div_den   = {1'b0, mag_reg, 8'b0} + {6'b0, mag_reg, 3'b0};

    cdjs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    logic [W_W-1:0] w_clamped;
    always_comb
    begin
        if (div_quot < OMEGA_MIN)
            w_clamped = W_W'(OMEGA_MIN);
        else if (div_quot > OMEGA_MAX)
            w_clamped = W_W'(OMEGA_MAX);
        else
            w_clamped = div_quot[W_W-1:0];
    end

    // shared MAC: operand selection per micro-step
    logic                     mac_issue;
    cdjs_mac_op_t             mac_op;
    logic signed [MA_W-1:0]   mac_a;
    logic signed [MB_W-1:0]   mac_b;
    logic                     mac_done;
    logic signed [ACC_W-1:0]  mac_acc;
    logic signed [POS_W-1:0]  cur_p, cur_v;
    logic signed [ERR_W-1:0]  cur_e;
    logic signed [MB_W-1:0]   w_op, dt_op;

    assign cur_p = stage_reg ? p2_reg : p1_reg;
    assign cur_v = stage_reg ? v2_reg : v1_reg;
    assign cur_e = stage_reg ? (ERR_W'(p1_reg) - ERR_W'(p2_reg)) : err1;
    assign w_op  = {1'b0, w_reg};
    assign dt_op = {2'b0, dt_reg};
    assign mac_issue = (state_reg == S_MAC) && !wait_reg;

    always_comb
    begin
        mac_op = '{clr: 1'b1, sub: 1'b0, shift: SH_0};
        mac_a  = MA_W'(cur_e);
        mac_b  = w_op;
        case (step_reg)
            3'd0:
            begin
                mac_a = MA_W'(cur_e);
            end
            3'd1:
            begin
                mac_a = {17'b0, t_reg[16:0]};
            end
            3'd2:
            begin
                mac_op = '{clr: 1'b0, sub: 1'b0, shift: SH_17};
                mac_a  = MA_W'($signed(t_reg[T_W-1:17]));
            end
            3'd3:
            begin
                mac_op = '{clr: 1'b0, sub: 1'b1, shift: SH_1};
                mac_a  = MA_W'(cur_v);
            end
            3'd4:
            begin
                mac_a = {17'b0, accv_reg[16:0]};
                mac_b = dt_op;
            end
            3'd5:
            begin
                mac_op = '{clr: 1'b0, sub: 1'b0, shift: SH_17};
                mac_a  = MA_W'($signed(accv_reg[ACCV_W-1:17]));
                mac_b  = dt_op;
            end
            default:
            begin
                mac_a = MA_W'(cur_v);
                mac_b = dt_op;
            end
        endcase
    end

    cdjs_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (mac_issue),
        .op    (mac_op),
        .a     (mac_a),
        .b     (mac_b),
        .done  (mac_done),
        .acc   (mac_acc)
    );

    // post-processing of MAC results
    logic signed [59:0]      acc_sh16;
    logic signed [T_W-1:0]   t_next;
    logic signed [POS_W-1:0] upd_next;

    assign acc_sh16 = mac_acc[ACC_W-1:16];

    always_comb
    begin
        if (acc_sh16 > TERM_LIMIT)
            t_next = T_W'(TERM_LIMIT);
        else if (acc_sh16 < -TERM_LIMIT)
            t_next = T_W'(-TERM_LIMIT);
        else
            t_next = acc_sh16[T_W-1:0];
        // v + acc*dt/2^24 or p + v*dt/2^24, both saturated
        upd_next = sat32(53'(step_reg == 3'd5 ? cur_v : cur_p)
                         + 53'($signed(mac_acc[ACC_W-1:24])));
    end

    logic slot_free;
    assign slot_free = !out_valid_reg || out_ready;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            wait_reg      <= 1'b0;
            mv_reg        <= 24'd16384;
            for (int i = 0; i < JOINT_COUNT; i++)
            begin
                seeded_reg[i]  <= 1'b0;
                seq_mem_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
                mv_reg <= cfg_write_data;
            if (state_reg == S_DONE && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= in_range ? S_PREP : S_DONE;
                end
                S_PREP:
                begin
                    state_reg <= S_DIVGO;
                end
                S_DIVGO:
                begin
                    state_reg <= (mag_reg == '0) ? S_MAC : S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (!wait_reg)
                        wait_reg <= 1'b1;
                    else if (mac_done)
                    begin
                        wait_reg <= 1'b0;
                        if (step_reg == 3'd6 && stage_reg)
                        begin
                            state_reg            <= S_DONE;
                            seeded_reg[idx_reg]  <= 1'b1;
                            seq_mem_reg[idx_reg] <= seq_reg;
                        end
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            idx_reg   <= idx_in;
            joint_reg <= joint;
            gp_reg    <= gp_ld;
            p1_reg    <= p1_ld;
            v1_reg    <= v1_ld;
            p2_reg    <= p2_ld;
            v2_reg    <= v2_ld;
            seq_reg   <= seq_ld;
            dt_reg    <= (period == '0) ? DT_DEFAULT : period;
            cmd_reg   <= '0;
            stage_reg <= 1'b0;
            step_reg  <= 3'd0;
        end
        if (state_reg == S_PREP)
            mag_reg <= err1[ERR_W-1] ? ERR_W'(-err1) : ERR_W'(err1);
        if (state_reg == S_DIVGO && mag_reg == '0)
            w_reg <= W_W'(OMEGA_MAX);
        if (state_reg == S_DIV && div_done)
            w_reg <= w_clamped;
        if (state_reg == S_MAC && wait_reg && mac_done)
        begin
            if (step_reg == 3'd6)
                step_reg <= 3'd0;
            else
                step_reg <= step_reg + 3'd1;
            case (step_reg)
                3'd0: t_reg    <= t_next;
                3'd3: accv_reg <= mac_acc[ACCV_W+15:16];
                3'd5:
                begin
                    if (stage_reg)
                        v2_reg <= upd_next;
                    else
                        v1_reg <= upd_next;
                end
                3'd6:
                begin
                    if (stage_reg)
                    begin
                        p2_reg               <= upd_next;
                        cmd_reg              <= upd_next;
                        goal_reg[idx_reg]    <= gp_reg;
                        p1_mem_reg[idx_reg]  <= p1_reg;
                        v1_mem_reg[idx_reg]  <= v1_reg;
                        p2_mem_reg[idx_reg]  <= upd_next;
                        v2_mem_reg[idx_reg]  <= v2_reg;
                    end
                    else
                    begin
                        p1_reg    <= upd_next;
                        stage_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == S_DONE && slot_free)
        begin
            joint_out_reg <= joint_reg;
            command_reg   <= cmd_reg;
        end
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = out_valid_reg;
    assign joint_out        = joint_out_reg;
    assign command_position = command_reg;

endmodule

// ----- rtl/cdjs_chk.sv -----
// Port-level checker for the smoother core, bound to the top level.
module cdjs_chk
    import cdjs_pkg::*;
#(
    parameter int JOINT_COUNT = 7
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [2:0]              joint_out,
    input logic signed [POS_W-1:0] command_position
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command_position)
                                    && $stable(joint_out))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after a transfer");

    a_busy_two: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 !in_ready || out_valid)
        else $error("tick finished with no result");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (32'(joint_out) >= JOINT_COUNT) |-> command_position == '0)
        else $error("out-of-range joint gave nonzero command");
endmodule

bind cascaded_damped_joint_smoother_core cdjs_chk #(.JOINT_COUNT(JOINT_COUNT)) u_cdjs_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .joint_out        (joint_out),
    .command_position (command_position)
);
